FILE: rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants for the distance-vector route table core.
// ----------------------------------------------------------------------------
`default_nettype none
package dvrt_pkg;

  localparam int TABLE_DEPTH    = 32;
  localparam int PACKET_ENTRIES = 25;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
  localparam int PKT_W          = $clog2(PACKET_ENTRIES + 1);

  localparam logic [4:0] INFINITE_METRIC = 5'd16;
  localparam logic [6:0] PAD_METRIC      = 7'd100;
  localparam logic [1:0] REAL_TAG        = 2'd2;
  localparam logic [7:0] EXPIRE_RESET    = 8'd20;
  localparam logic [7:0] AGE_MAX         = 8'd255;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_ADV  = 3'd1;
  localparam logic [2:0] OP_EOP  = 3'd2;
  localparam logic [2:0] OP_TICK = 3'd3;
  localparam logic [2:0] OP_DUMP = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [4:0]  metric;
    logic [3:0]  iface;
    logic [7:0]  age;
  } route_t;

endpackage
`default_nettype wire

FILE: rtl/dvrt_in_if.sv
// ----------------------------------------------------------------------------
// dvrt_in_if
// Operation channel: one word per table operation.
// ----------------------------------------------------------------------------
`default_nettype none
interface dvrt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] dst_net;
  logic [31:0] net_mask;
  logic [31:0] gateway;
  logic [31:0] route_metric;
  logic [15:0] entry_tag;
  logic [31:0] source_addr;
  logic [3:0]  iface_index;

  modport source (output valid, operation, dst_net, net_mask, gateway, route_metric,
                  entry_tag, source_addr, iface_index, input ready);
  modport sink   (input valid, operation, dst_net, net_mask, gateway, route_metric,
                  entry_tag, source_addr, iface_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/dvrt_out_if.sv
// ----------------------------------------------------------------------------
// dvrt_out_if
// Result channel: status words and dumped route entries.
// ----------------------------------------------------------------------------
`default_nettype none
interface dvrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        changed;
  logic [31:0] out_dest;
  logic [31:0] out_mask;
  logic [31:0] out_next_hop;
  logic [6:0]  out_metric;
  logic [1:0]  out_tag;
  logic        last;

  modport source (output valid, status, changed, out_dest, out_mask, out_next_hop,
                  out_metric, out_tag, last, input ready);
  modport sink   (input valid, status, changed, out_dest, out_mask, out_next_hop,
                  out_metric, out_tag, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/dvrt_cfg_if.sv
// ----------------------------------------------------------------------------
// dvrt_cfg_if
// Configuration write channel for the expiry limit.
// ----------------------------------------------------------------------------
`default_nettype none
interface dvrt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/distance_vector_route_table_core.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_core
// Ordered route table: add, advertise, end of packet, tick aging, dump.
// ----------------------------------------------------------------------------
// Add: append state, then response state with output hand-off. Advertise, end of
// packet and tick walk the table through one read port, a read and a process
// state per entry, then respond; an appending advertisement adds the append state.
// Dump: the same walk emits route words, then padding words; 25 words out.
// One operation at a time; in ready only between operations.
// Synchronous active-low reset empties the table and sets the expiry limit to 20.
`default_nettype none
module distance_vector_route_table_core
  import dvrt_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  dvrt_in_if.sink     in_ch,
  dvrt_out_if.source  out_ch,
  dvrt_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_PROC, S_APPEND, S_RESP, S_PAD} state_t;

  state_t      state_r;
  logic [2:0]  op_r;
  logic [31:0] dest_r, mask_r, gw_r, src_r;
  logic [4:0]  met_r;
  logic [3:0]  ifc_r;
  logic [CNT_W-1:0] idx_r, wr_r, cnt_r;
  logic [PKT_W-1:0] k_r;
  logic        found_r, chg_r, resp_chg_r;
  logic [1:0]  resp_st_r;
  logic [7:0]  expire_r;

  logic        out_valid_r, out_changed_r, out_last_r;
  logic [1:0]  out_status_r, out_tag_r;
  logic [31:0] out_dest_r, out_mask_r, out_gw_r;
  logic [6:0]  out_metric_r;

  route_t mem [TABLE_DEPTH];
  route_t q_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  route_t           mem_wd;

  logic       slot_free, adv_bad, upd, keep, full;
  logic [4:0] nm, add_met;
  logic [7:0] aged;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign adv_bad   = (in_ch.entry_tag == 16'd0) || (in_ch.dst_net == 32'd0) ||
                     (in_ch.net_mask == 32'd0) || (in_ch.route_metric >= 32'd16);
  assign nm        = met_r + 5'd1;
  assign upd       = (q_r.dest == dest_r) && (nm < q_r.metric) && (nm < INFINITE_METRIC);
  assign aged      = (q_r.age == AGE_MAX) ? AGE_MAX : q_r.age + 8'd1;
  assign keep      = aged <= expire_r;
  assign full      = cnt_r >= CNT_W'(TABLE_DEPTH);
  assign add_met   = (in_ch.route_metric > 32'd16) ? INFINITE_METRIC : in_ch.route_metric[4:0];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.changed      = out_changed_r;
  assign out_ch.out_dest     = out_dest_r;
  assign out_ch.out_mask     = out_mask_r;
  assign out_ch.out_next_hop = out_gw_r;
  assign out_ch.out_metric   = out_metric_r;
  assign out_ch.out_tag      = out_tag_r;
  assign out_ch.last         = out_last_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r[IDX_W-1:0];
    mem_wd = q_r;
    case (state_r)
      S_PROC: begin
        case (op_r)
          OP_ADV: begin
            if (upd) begin
              mem_we        = 1'b1;
              mem_wd.gw     = src_r;
              mem_wd.metric = nm;
              mem_wd.iface  = ifc_r;
              mem_wd.age    = 8'd0;
            end
          end
          OP_EOP: begin
            mem_we     = 1'b1;
            mem_wd.age = 8'd0;
          end
          OP_TICK: begin
            mem_we     = keep;
            mem_wa     = wr_r[IDX_W-1:0];
            mem_wd.age = aged;
          end
          default: ;
        endcase
      end
      S_APPEND: begin
        mem_we        = !full;
        mem_wa        = cnt_r[IDX_W-1:0];
        mem_wd.dest   = dest_r;
        mem_wd.mask   = mask_r;
        mem_wd.gw     = (op_r == OP_ADV) ? src_r : gw_r;
        mem_wd.metric = (op_r == OP_ADV) ? nm : met_r;
        mem_wd.iface  = ifc_r;
        mem_wd.age    = 8'd0;
      end
      default: ;
    endcase
  end

  // one read port and one write port: registered read of the walk index
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    q_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      chg_r       <= 1'b0;
      expire_r    <= EXPIRE_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cfg_ch.valid) expire_r <= cfg_ch.data;
      if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r       <= in_ch.operation;
            dest_r     <= in_ch.dst_net;
            mask_r     <= in_ch.net_mask;
            gw_r       <= in_ch.gateway;
            src_r      <= in_ch.source_addr;
            ifc_r      <= in_ch.iface_index;
            met_r      <= (in_ch.operation == OP_ADD) ? add_met : in_ch.route_metric[4:0];
            idx_r      <= '0;
            wr_r       <= '0;
            k_r        <= '0;
            found_r    <= 1'b0;
            resp_st_r  <= ST_OK;
            resp_chg_r <= 1'b0;
            case (in_ch.operation)
              OP_ADD: state_r <= S_APPEND;
              OP_ADV: begin
                if (adv_bad) begin
                  resp_st_r <= ST_IGNORED;
                  state_r   <= S_RESP;
                end else begin
                  state_r <= S_RD;
                end
              end
              OP_EOP, OP_TICK, OP_DUMP: state_r <= S_RD;
              default: begin
                resp_st_r <= ST_IGNORED;
                state_r   <= S_RESP;
              end
            endcase
          end
        end
        S_RD: begin
          if (idx_r < cnt_r) begin
            state_r <= S_PROC;
          end else begin
            case (op_r)
              OP_ADV:  state_r <= found_r ? S_RESP : S_APPEND;
              OP_EOP: begin
                resp_chg_r <= chg_r;
                chg_r      <= 1'b0;
                state_r    <= S_RESP;
              end
              OP_TICK: begin
                cnt_r   <= wr_r;
                state_r <= S_RESP;
              end
              default: state_r <= S_PAD;
            endcase
          end
        end
        S_PROC: begin
          if (op_r == OP_DUMP && q_r.iface != ifc_r && k_r < PKT_W'(PACKET_ENTRIES)) begin
            // emit one route word; hold here while the output slot is busy
            if (slot_free) begin
              out_valid_r   <= 1'b1;
              out_status_r  <= ST_OK;
              out_changed_r <= 1'b0;
              out_dest_r    <= q_r.dest;
              out_mask_r    <= q_r.mask;
              out_gw_r      <= q_r.gw;
              out_metric_r  <= 7'(q_r.metric);
              out_tag_r     <= REAL_TAG;
              out_last_r    <= (k_r == PKT_W'(PACKET_ENTRIES - 1));
              k_r           <= k_r + 1'b1;
              idx_r         <= idx_r + 1'b1;
              state_r       <= S_RD;
            end
          end else begin
            if (op_r == OP_ADV && q_r.dest == dest_r) found_r <= 1'b1;
            if (op_r == OP_ADV && upd) chg_r <= 1'b1;
            if (op_r == OP_TICK && keep) wr_r <= wr_r + 1'b1;
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_APPEND: begin
          if (full) begin
            resp_st_r <= ST_FULL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            if (op_r == OP_ADV) chg_r <= 1'b1;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= resp_st_r;
            out_changed_r <= resp_chg_r;
            out_dest_r    <= '0;
            out_mask_r    <= '0;
            out_gw_r      <= '0;
            out_metric_r  <= '0;
            out_tag_r     <= '0;
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        S_PAD: begin
          if (k_r >= PKT_W'(PACKET_ENTRIES)) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= ST_OK;
            out_changed_r <= 1'b0;
            out_dest_r    <= '0;
            out_mask_r    <= '0;
            out_gw_r      <= '0;
            out_metric_r  <= PAD_METRIC;
            out_tag_r     <= '0;
            out_last_r    <= (k_r == PKT_W'(PACKET_ENTRIES - 1));
            k_r           <= k_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dvrt_checker.sv
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks for the route table core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dvrt_checker
  import dvrt_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire [31:0] out_dest,
  input wire [6:0]  out_metric,
  input wire [1:0]  out_tag,
  input wire        out_last
);

  // in ready drops in the cycle after an operation is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in ready right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest) && $stable(out_last))
    else $error("result word dropped while stalled");

  // a real dumped route never carries a metric above infinity
  a_real_metric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tag == REAL_TAG |->
      out_metric <= {2'b00, INFINITE_METRIC} && out_status == ST_OK)
    else $error("bad metric on dumped route");

  // only dump words come without last, and they are ok status
  a_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK &&
      (out_tag == REAL_TAG || (out_metric == PAD_METRIC && out_dest == 32'd0)))
    else $error("non-final word is not a dump entry");

endmodule

bind distance_vector_route_table_core dvrt_checker u_dvrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_dest   (out_ch.out_dest),
  .out_metric (out_ch.out_metric),
  .out_tag    (out_ch.out_tag),
  .out_last   (out_ch.last)
);
`default_nettype wire
